@@ rtl/core/b32fpd_pkg.sv @@
// Package for the base32 fingerprint decoder.
// Holds the symbol and result types and the letter lookup table.
// No dependencies.
package b32fpd_pkg;

  localparam int SYM_BITS   = 5;
  localparam int BYTE_BITS  = 8;
  localparam int INDEX_BITS = 5;
  localparam int LETTERS    = 26;

  typedef struct packed {
    logic                bad;
    logic [SYM_BITS-1:0] value;
  } sym_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0]  id_byte;
    logic [INDEX_BITS-1:0] byte_index;
    logic                  last;
    logic                  error;
  } result_t;

  // Bit 5 marks a letter that is not in the alphabet (a, e, i, o).
  localparam logic [5:0] BAD_SYM = 6'h20;

  localparam logic [5:0] LETTER_TABLE [LETTERS] = '{
    BAD_SYM, 6'd10, 6'd11, 6'd12, BAD_SYM, 6'd13, 6'd14, 6'd15, BAD_SYM,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, BAD_SYM, 6'd21, 6'd22, 6'd23,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31
  };

endpackage

@@ rtl/core/b32fpd_symbol_map.sv @@
// Maps one ASCII character to its five-bit base32 value, case-insensitive.
// Depends on b32fpd_pkg.
module b32fpd_symbol_map
  import b32fpd_pkg::*;
(
  input  logic [7:0] char_i,
  output sym_t       sym_o
);

  logic [7:0] offset;

  always_comb begin
    sym_o  = sym_t'(BAD_SYM);
    offset = 8'h00;
    case (char_i) inside
      [8'h30:8'h39]: begin
        offset = char_i - 8'h30;
        sym_o  = '{bad: 1'b0, value: offset[SYM_BITS-1:0]};
      end
      [8'h41:8'h5a]: begin
        offset = char_i - 8'h41;
        sym_o  = sym_t'(LETTER_TABLE[offset[4:0]]);
      end
      [8'h61:8'h7a]: begin
        offset = char_i - 8'h61;
        sym_o  = sym_t'(LETTER_TABLE[offset[4:0]]);
      end
      default: begin
        sym_o = sym_t'(BAD_SYM);
      end
    endcase
  end

endmodule

@@ rtl/core/b32fpd_packer.sv @@
// Frame state and bit packing: gathers five-bit symbols LSB first into bytes.
// Depends on b32fpd_pkg.
module b32fpd_packer
  import b32fpd_pkg::*;
#(
  parameter int ID_BYTES    = 32,
  parameter int FRAME_CHARS = 52
)(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    advance_i,
  input  sym_t    sym_i,
  output logic    emit_o,
  output result_t res_o
);

  localparam int POS_W = $clog2(FRAME_CHARS);
  localparam int CNT_W = $clog2(ID_BYTES + 1);

  logic [POS_W-1:0] pos_r,    pos_nxt;
  logic [CNT_W-1:0] bytes_r,  bytes_nxt;
  logic [6:0]       pend_r,   pend_nxt;
  logic [2:0]       held_r,   held_nxt;
  logic             failed_r, failed_nxt;

  logic [11:0] acc;
  logic [3:0]  held_sum;
  logic [31:0] bytes_ext;

  always_comb begin
    acc        = 12'(pend_r) | (12'(sym_i.value) << held_r);
    held_sum   = 4'(held_r) + 4'd5;
    bytes_ext  = 32'(bytes_r);
    emit_o     = 1'b0;
    res_o      = '0;
    bytes_nxt  = bytes_r;
    pend_nxt   = pend_r;
    held_nxt   = held_r;
    failed_nxt = failed_r;

    if (!failed_r) begin
      if (sym_i.bad) begin
        failed_nxt  = 1'b1;
        emit_o      = 1'b1;
        res_o.error = 1'b1;
      end else if (bytes_r < CNT_W'(ID_BYTES)) begin
        if (held_sum >= 4'd8) begin
          emit_o           = 1'b1;
          res_o.id_byte    = acc[7:0];
          res_o.byte_index = bytes_ext[INDEX_BITS-1:0];
          res_o.last       = (bytes_r == CNT_W'(ID_BYTES - 1));
          bytes_nxt        = bytes_r + 1'b1;
          pend_nxt         = 7'(acc >> 8);
          held_nxt         = 3'(held_sum - 4'd8);
        end else begin
          pend_nxt = acc[6:0];
          held_nxt = held_sum[2:0];
        end
      end
    end

    if (pos_r == POS_W'(FRAME_CHARS - 1)) begin
      pos_nxt    = '0;
      bytes_nxt  = '0;
      pend_nxt   = '0;
      held_nxt   = '0;
      failed_nxt = 1'b0;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      bytes_r  <= '0;
      pend_r   <= '0;
      held_r   <= '0;
      failed_r <= 1'b0;
    end else if (advance_i) begin
      pos_r    <= pos_nxt;
      bytes_r  <= bytes_nxt;
      pend_r   <= pend_nxt;
      held_r   <= held_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

@@ rtl/core/base32_fingerprint_decoder_unit.sv @@
// Top level of the base32 fingerprint decoder: input register, packer, result register.
// Depends on b32fpd_pkg, b32fpd_symbol_map and b32fpd_packer.
//
// Usage: each input item carries one ASCII character of a fingerprint on
// in_char_code, handed over with in_valid/in_ready. A frame is FRAME_CHARS
// characters; the decoded symbols are packed least significant bit first and
// every identifier byte leaves on the result channel (out_valid/out_ready)
// as soon as it is complete, with its position in out_byte_index and
// out_last set on byte ID_BYTES-1. A character outside the alphabet gives a
// single item with out_error set, and the rest of that frame gives nothing.
// A character is taken into the input register, and its result, if any, is
// then loaded into the result register, whence it is presented. Throughput
// is one character per cycle while the receiver keeps up; the only loop is
// the frame state inside the packer. When the receiver stalls with a result
// waiting, the character in the input register holds until the result
// register frees, and in_ready then falls; a character that gives no result
// still waits behind the held result so that order is kept. Synchronous
// reset (rst_n low) empties both registers and returns the frame to its
// first character.
module base32_fingerprint_decoder_unit
  import b32fpd_pkg::*;
#(
  parameter int ID_BYTES    = 32,
  parameter int FRAME_CHARS = 52
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_char_code,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BYTE_BITS-1:0]  out_id_byte,
  output logic [INDEX_BITS-1:0] out_byte_index,
  output logic                  out_last,
  output logic                  out_error
);

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] char_r;
  logic       out_vld_r, out_vld_nxt;
  result_t    res_r;

  logic    advance;
  logic    emit;
  sym_t    sym;
  result_t res;

  // The input register moves on whenever the result register has room.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  b32fpd_symbol_map u_symbol_map (
    .char_i (char_r),
    .sym_o  (sym)
  );

  b32fpd_packer #(
    .ID_BYTES    (ID_BYTES),
    .FRAME_CHARS (FRAME_CHARS)
  ) u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance_i (advance),
    .sym_i     (sym),
    .emit_o    (emit),
    .res_o     (res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    if (advance && emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r <= in_char_code;
    end
    if (advance && emit) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_id_byte    = res_r.id_byte;
  assign out_byte_index = res_r.byte_index;
  assign out_last       = res_r.last;
  assign out_error      = res_r.error;

endmodule
